// ----- rtl/pqsc_pkg.sv -----
package pqsc_pkg;

  localparam int MaxSegments = 64;
  localparam int MaxKnots    = MaxSegments + 1;
  localparam int KnotAw      = $clog2(MaxKnots);
  localparam int SegAw       = $clog2(MaxSegments);
  localparam int CountW      = $clog2(MaxKnots + 1);

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEven     = 2'd1;
  localparam logic [1:0] StZero     = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic signed [47:0] Q48Max = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q48Min = 48'sh8000_0000_0000;

  typedef struct packed {
    logic signed [31:0] knot_x;
    logic signed [31:0] knot_y;
    logic               final_knot;
  } knot_t;

  typedef struct packed {
    logic signed [47:0] coef_quad;
    logic signed [47:0] coef_lin;
    logic signed [47:0] coef_const;
    logic [5:0]         segment_index;
    logic [1:0]         status;
    logic               last_result;
  } coef_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SLOPE_RD, S_SLOPE_DIV, S_SUM, S_BACK,
    S_OUT_RD, S_OUT_DIV, S_OUT_EMIT
  } state_e;

  function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
    if (v > 56'(Q48Max)) return Q48Max;
    if (v < 56'(Q48Min)) return Q48Min;
    return v[47:0];
  endfunction

endpackage

// ----- rtl/pqsc_div.sv -----
// signed (num << sh) / den, truncated toward zero, saturated to 48 bits
// restoring divider, one quotient bit per cycle over 80 bits
module pqsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [55:0] num_i,
  input  logic signed [32:0] den_i,
  input  logic               sh24_i,
  output logic               done_o,
  output logic signed [47:0] quot_o
);
  localparam int NW = 80;

  logic [NW-1:0] n_q, n_d;
  logic [33:0]   r_q, r_d;
  logic [32:0]   d_q, d_d;
  logic          neg_q, neg_d;
  logic [6:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [55:0]   mag;
  logic [34:0]   trial;
  logic [NW-1:0] qmag;
  logic [47:0]   lim;

  always_comb begin
    mag = num_i[55] ? 56'(-num_i) : 56'(num_i);
    n_d = n_q; r_d = r_q; d_d = d_q; neg_d = neg_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = {r_q, n_q[NW-1]} - {2'b0, d_q};
    if (start_i) begin
      n_d    = sh24_i ? {mag, 24'b0} : {8'b0, mag, 16'b0};
      r_d    = '0;
      d_d    = den_i[32] ? 33'(-den_i) : 33'(den_i);
      neg_d  = num_i[55] ^ den_i[32];
      cnt_d  = 7'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[34]) begin
        r_d = trial[33:0];
        n_d = {n_q[NW-2:0], 1'b1};
      end else begin
        r_d = {r_q[32:0], n_q[NW-1]};
        n_d = {n_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  // quotient ready in the cycle after the last step
  logic fin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      fin_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      fin_q  <= busy_q && (cnt_q == 7'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  always_comb begin
    qmag   = n_q;
    lim    = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    quot_o = '0;
    if (qmag > NW'(lim)) begin
      quot_o = neg_q ? pqsc_pkg::Q48Min : pqsc_pkg::Q48Max;
    end else begin
      quot_o = neg_q ? 48'(-qmag[47:0]) : qmag[47:0];
    end
  end

  assign done_o = fin_q;
endmodule

// ----- rtl/periodic_quadratic_spline_coefs.sv -----
// periodic quadratic spline coefficients: knots load one per cycle (busy
// stays low while loading). the word carrying final_knot raises busy for
// the solve: a scan of the knot memory, then per segment the slope (two
// knot reads and a serial division), an alternating-sum pass, a backward
// pass, and per segment the quadratic term and its result word; both
// per-segment steps share the one divider. an overflow or even-count
// status word comes from the check state before the scan, a zero-interval
// one right after the scan. results appear one per cycle at most on
// result_o with valid_o for exactly one cycle; the receiver cannot stall,
// and the block never holds a result waiting.
module periodic_quadratic_spline_coefs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  pqsc_pkg::knot_t        knot_i,
  output logic                   valid_o,
  output pqsc_pkg::coef_t        result_o
);
  localparam int KA = pqsc_pkg::KnotAw;
  localparam int SA = pqsc_pkg::SegAw;
  localparam int CW = pqsc_pkg::CountW;

  // knot memory (x,y), slope memory, linear coefficient memory
  logic [63:0] knot_mem [pqsc_pkg::MaxKnots];
  logic [47:0] slope_mem [pqsc_pkg::MaxSegments];
  logic [47:0] lin_mem [pqsc_pkg::MaxSegments];

  pqsc_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          rdv_q, rdv_d;       // read data pipeline valid
  logic          zero_q, zero_d;
  logic [63:0]   kprev_q, kprev_d;   // previous knot read
  logic [63:0]   krd_q;
  logic [KA-1:0] kaddr;
  logic [SA-1:0] saddr, laddr, swaddr, lwaddr;
  logic [47:0]   srd_q, lrd_q, swdata, lwdata;
  logic          swe, lwe;
  logic signed [55:0] acc_q, acc_d;
  logic signed [47:0] bnext_q, bnext_d;
  logic [CW-1:0] nseg;
  logic [CW-1:0] lastseg;            // index of the last segment
  logic          accept;
  logic          dstart, ddone;
  logic signed [55:0] dnum;
  logic signed [32:0] dden;
  logic          dsh24;
  logic signed [47:0] dquot;
  pqsc_pkg::coef_t res_d, res_q;
  logic          vld_d, vld_q;

  assign accept  = start && !busy;
  assign nseg    = cnt_q - CW'(1);
  assign lastseg = cnt_q - CW'(2);

  pqsc_div u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(dden),
    .sh24_i(dsh24), .done_o(ddone), .quot_o(dquot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pqsc_pkg::S_IDLE:
        if (accept && knot_i.final_knot) begin
          state_d = pqsc_pkg::S_CHECK;
        end
      pqsc_pkg::S_CHECK:
        if (ovf_q || cnt_q < CW'(2) || !nseg[0]) begin
          state_d = pqsc_pkg::S_IDLE;
        end else if (rdv_q && idx_q == cnt_q) begin
          state_d = (zero_q || krd_q[63:32] == kprev_q[63:32]) ?
                    pqsc_pkg::S_IDLE : pqsc_pkg::S_SLOPE_RD;
        end
      pqsc_pkg::S_SLOPE_RD:  state_d = pqsc_pkg::S_SLOPE_DIV;
      pqsc_pkg::S_SLOPE_DIV:
        if (ddone) begin
          state_d = (idx_q == lastseg) ? pqsc_pkg::S_SUM : pqsc_pkg::S_SLOPE_RD;
        end
      pqsc_pkg::S_SUM:
        if (rdv_q && idx_q == lastseg) begin
          // a single segment has no backward pass
          state_d = (lastseg == CW'(0)) ? pqsc_pkg::S_OUT_RD : pqsc_pkg::S_BACK;
        end
      pqsc_pkg::S_BACK:
        if (rdv_q && idx_q == CW'(0)) begin
          state_d = pqsc_pkg::S_OUT_RD;
        end
      pqsc_pkg::S_OUT_RD:    state_d = pqsc_pkg::S_OUT_DIV;
      pqsc_pkg::S_OUT_DIV:
        if (ddone) begin
          state_d = pqsc_pkg::S_OUT_EMIT;
        end
      pqsc_pkg::S_OUT_EMIT:
        state_d = (idx_q == lastseg) ? pqsc_pkg::S_IDLE : pqsc_pkg::S_OUT_RD;
      default: state_d = pqsc_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; ovf_d = ovf_q; idx_d = idx_q; rdv_d = 1'b0;
    zero_d = zero_q; kprev_d = kprev_q; acc_d = acc_q; bnext_d = bnext_q;
    kaddr = KA'(idx_q); saddr = SA'(idx_q); laddr = SA'(idx_q);
    swe = 1'b0; swaddr = SA'(idx_q); swdata = dquot;
    lwe = 1'b0; lwaddr = SA'(idx_q); lwdata = '0;
    dsh24 = 1'b1;
    dnum = 56'(signed'(krd_q[31:0])) - 56'(signed'(kprev_q[31:0]));
    dden = 33'(signed'(krd_q[63:32])) - 33'(signed'(kprev_q[63:32]));
    vld_d = 1'b0; res_d = res_q;
    busy = (state_q != pqsc_pkg::S_IDLE);
    case (state_q)
      pqsc_pkg::S_IDLE: begin
        kaddr = KA'(cnt_q);
        if (accept) begin
          if (cnt_q < CW'(pqsc_pkg::MaxKnots)) begin
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          idx_d = '0; zero_d = 1'b0;
          if (knot_i.final_knot) begin
            rdv_d = 1'b0;
          end
        end
      end
      pqsc_pkg::S_CHECK: begin
        // sweep knots, compare each x with the previous one
        kaddr = KA'(idx_q);
        if (idx_q != cnt_q) begin
          idx_d = idx_q + CW'(1);
          rdv_d = 1'b1;
        end
        if (rdv_q) begin
          kprev_d = krd_q;
          if (idx_q != CW'(1) && krd_q[63:32] == kprev_q[63:32]) begin
            zero_d = 1'b1;
          end
        end
        if (state_d == pqsc_pkg::S_IDLE) begin
          vld_d = 1'b1;
          res_d = '0;
          res_d.last_result = 1'b1;
          res_d.status = ovf_q ? pqsc_pkg::StOverflow :
                         (cnt_q < CW'(2) || !nseg[0]) ? pqsc_pkg::StEven :
                         pqsc_pkg::StZero;
          cnt_d = '0; ovf_d = 1'b0;
        end
        if (state_d == pqsc_pkg::S_SLOPE_RD) begin
          idx_d = '0;
        end
      end
      pqsc_pkg::S_SLOPE_RD: begin
        kaddr = KA'(idx_q);
        rdv_d = 1'b1;
      end
      pqsc_pkg::S_SLOPE_DIV: begin
        // read the left knot, then the right knot
        if (rdv_q && !rdv_q) begin
          rdv_d = 1'b0;
        end
        kaddr = KA'(idx_q + CW'(1));
        if (rdv_q) begin
          kprev_d = krd_q;
          rdv_d   = 1'b0;
        end
        if (ddone) begin
          swe = 1'b1;
          if (idx_q == lastseg) begin
            idx_d = '0;
            acc_d = '0;
            rdv_d = 1'b0;
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      pqsc_pkg::S_SUM: begin
        saddr = SA'(idx_q);
        rdv_d = 1'b1;
        if (rdv_q) begin
          if (idx_q == lastseg) begin
            acc_d = acc_q + 56'(signed'(srd_q));
          end else if (idx_q[0]) begin
            acc_d = acc_q + 56'(signed'(srd_q));
          end else begin
            acc_d = acc_q - 56'(signed'(srd_q));
          end
          if (idx_q != lastseg) begin
            idx_d = idx_q + CW'(1);
            rdv_d = 1'b0;
          end
        end
        if (rdv_q && idx_q == lastseg) begin
          bnext_d = pqsc_pkg::sat48(acc_d);
          lwe = 1'b1; lwaddr = SA'(lastseg); lwdata = pqsc_pkg::sat48(acc_d);
          idx_d = (lastseg == CW'(0)) ? CW'(0) : lastseg - CW'(1);
          rdv_d = 1'b0;
        end
      end
      pqsc_pkg::S_BACK: begin
        saddr = SA'(idx_q);
        rdv_d = 1'b1;
        if (rdv_q) begin
          lwe = 1'b1;
          lwdata = pqsc_pkg::sat48(56'(signed'(srd_q)) * 56'sd2 - 56'(bnext_q));
          bnext_d = lwdata;
          rdv_d = 1'b0;
          if (idx_q != CW'(0)) begin
            idx_d = idx_q - CW'(1);
          end
        end
      end
      pqsc_pkg::S_OUT_RD: begin
        kaddr = KA'(idx_q); saddr = SA'(idx_q); laddr = SA'(idx_q);
        rdv_d = 1'b1;
      end
      pqsc_pkg::S_OUT_DIV: begin
        kaddr = KA'(idx_q + CW'(1));
        dsh24 = 1'b0;
        if (rdv_q) begin
          kprev_d = krd_q;
          res_d.coef_lin   = lrd_q;
          res_d.coef_const = 48'(signed'(krd_q[31:0])) <<< 8;
          acc_d = 56'(signed'(srd_q)) - 56'(signed'(lrd_q));
        end
      end
      pqsc_pkg::S_OUT_EMIT: begin
        vld_d = 1'b1;
        res_d.coef_quad     = dquot;
        res_d.segment_index = 6'(idx_q);
        res_d.status        = pqsc_pkg::StOk;
        res_d.last_result   = (idx_q == lastseg);
        idx_d = idx_q + CW'(1);
        if (idx_q == lastseg) begin
          cnt_d = '0; ovf_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (state_q == pqsc_pkg::S_OUT_DIV) begin
      dnum = acc_q;
    end
  end

  // divider kick: in the same cycle as the right knot read lands
  logic kick_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_q <= 1'b0;
    end else begin
      kick_q <= (state_q == pqsc_pkg::S_SLOPE_DIV || state_q == pqsc_pkg::S_OUT_DIV)
                && rdv_q;
    end
  end
  logic started_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (kick_q) begin
      started_q <= 1'b1;
    end else if (ddone) begin
      started_q <= 1'b0;
    end
  end
  assign dstart = kick_q && !started_q;

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q < CW'(pqsc_pkg::MaxKnots)) begin
      knot_mem[KA'(cnt_q)] <= {knot_i.knot_x, knot_i.knot_y};
    end
    krd_q <= knot_mem[kaddr];
    if (swe) begin
      slope_mem[swaddr] <= swdata;
    end
    srd_q <= slope_mem[saddr];
    if (lwe) begin
      lin_mem[lwaddr] <= lwdata;
    end
    lrd_q <= lin_mem[laddr];
    kprev_q <= kprev_d;
    acc_q   <= acc_d;
    bnext_q <= bnext_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqsc_pkg::S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      rdv_q   <= 1'b0;
      zero_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      rdv_q   <= rdv_d;
      zero_q  <= zero_d;
      vld_q   <= vld_d;
    end
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;
endmodule
